// File: rtl/akd_pkg.sv
`timescale 1ns / 1ps

package akd_pkg;

    localparam int THR_BITS      = 10;
    localparam int DELAY_BITS    = 16;
    localparam int KEY_BITS      = 3;
    localparam int KIND_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [KEY_BITS-1:0] {
        KEY_NONE   = 3'd0,
        KEY_RIGHT  = 3'd1,
        KEY_DOWN   = 3'd2,
        KEY_UP     = 3'd3,
        KEY_LEFT   = 3'd4,
        KEY_SELECT = 3'd5
    } key_t;

    typedef enum logic [KIND_BITS-1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_UP   = 2'd2,
        EV_LONG = 2'd3
    } kind_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_NONE_THR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT_THR  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_THR   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UP_THR     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT_THR   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_DELAY = 3'd5;

    localparam logic [THR_BITS-1:0]   NONE_THR_RESET   = 10'd850;
    localparam logic [THR_BITS-1:0]   RIGHT_THR_RESET  = 10'd50;
    localparam logic [THR_BITS-1:0]   DOWN_THR_RESET   = 10'd250;
    localparam logic [THR_BITS-1:0]   UP_THR_RESET     = 10'd450;
    localparam logic [THR_BITS-1:0]   LEFT_THR_RESET   = 10'd650;
    localparam logic [DELAY_BITS-1:0] LONG_DELAY_RESET = 16'd1000;

    typedef struct packed {
        logic [THR_BITS-1:0]   none_thr;
        logic [THR_BITS-1:0]   right_thr;
        logic [THR_BITS-1:0]   down_thr;
        logic [THR_BITS-1:0]   up_thr;
        logic [THR_BITS-1:0]   left_thr;
        logic [DELAY_BITS-1:0] long_delay;
    } cfg_t;

endpackage

// File: rtl/akd_channels.sv
`timescale 1ns / 1ps

interface akd_sample_if #(
    parameter int SAMPLE_BITS = 10,
    parameter int TIME_BITS   = 32
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic [TIME_BITS-1:0]   now_time;

    modport source (output valid, output adc_sample, output now_time, input ready);
    modport sink   (input valid, input adc_sample, input now_time, output ready);
endinterface

interface akd_event_if;
    logic                          valid;
    logic                          ready;
    logic [akd_pkg::KIND_BITS-1:0] event_kind;
    logic [akd_pkg::KEY_BITS-1:0]  event_key;

    modport source (output valid, output event_kind, output event_key, input ready);
    modport sink   (input valid, input event_kind, input event_key, output ready);
endinterface

interface akd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [akd_pkg::CFG_IDX_BITS-1:0]  index;
    logic [akd_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/akd_cfg_regs.sv
`timescale 1ns / 1ps

module akd_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    akd_cfg_if.sink        cfg,
    output akd_pkg::cfg_t  regs
);

    akd_pkg::cfg_t cfg_reg;
    akd_pkg::cfg_t cfg_next;
    logic          write_en;

    assign cfg.ready = 1'b1;
    assign write_en  = cfg.valid;
    assign regs      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (cfg.index)
                akd_pkg::REG_NONE_THR:
                    cfg_next.none_thr = cfg.data[akd_pkg::THR_BITS-1:0];
                akd_pkg::REG_RIGHT_THR:
                    cfg_next.right_thr = cfg.data[akd_pkg::THR_BITS-1:0];
                akd_pkg::REG_DOWN_THR:
                    cfg_next.down_thr = cfg.data[akd_pkg::THR_BITS-1:0];
                akd_pkg::REG_UP_THR:
                    cfg_next.up_thr = cfg.data[akd_pkg::THR_BITS-1:0];
                akd_pkg::REG_LEFT_THR:
                    cfg_next.left_thr = cfg.data[akd_pkg::THR_BITS-1:0];
                akd_pkg::REG_LONG_DELAY:
                    cfg_next.long_delay = cfg.data[akd_pkg::DELAY_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.none_thr   <= akd_pkg::NONE_THR_RESET;
            cfg_reg.right_thr  <= akd_pkg::RIGHT_THR_RESET;
            cfg_reg.down_thr   <= akd_pkg::DOWN_THR_RESET;
            cfg_reg.up_thr     <= akd_pkg::UP_THR_RESET;
            cfg_reg.left_thr   <= akd_pkg::LEFT_THR_RESET;
            cfg_reg.long_delay <= akd_pkg::LONG_DELAY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/akd_classify.sv
`timescale 1ns / 1ps

module akd_classify #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  akd_pkg::cfg_t          regs,
    output akd_pkg::key_t          key
);

    localparam int CMP_BITS = (SAMPLE_BITS > akd_pkg::THR_BITS) ?
                              SAMPLE_BITS : akd_pkg::THR_BITS;

    logic [CMP_BITS-1:0] s;

    assign s = CMP_BITS'(sample);

    always_comb
    begin
        priority if (s > CMP_BITS'(regs.none_thr))
            key = akd_pkg::KEY_NONE;
        else if (s < CMP_BITS'(regs.right_thr))
            key = akd_pkg::KEY_RIGHT;
        else if (s < CMP_BITS'(regs.down_thr))
            key = akd_pkg::KEY_DOWN;
        else if (s < CMP_BITS'(regs.up_thr))
            key = akd_pkg::KEY_UP;
        else if (s < CMP_BITS'(regs.left_thr))
            key = akd_pkg::KEY_LEFT;
        else
            key = akd_pkg::KEY_SELECT;
    end

endmodule

// File: rtl/akd_tracker.sv
`timescale 1ns / 1ps

module akd_tracker #(
    parameter int SAMPLE_BITS = 10,
    parameter int TIME_BITS   = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    akd_sample_if.sink             samples,
    akd_event_if.source            events,
    input  akd_pkg::cfg_t          regs,
    output logic [SAMPLE_BITS-1:0] held_sample,
    input  akd_pkg::key_t          key
);

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic [TIME_BITS-1:0]   in_time_reg;

    logic                   out_valid_reg;
    akd_pkg::kind_t         out_kind_reg;
    akd_pkg::key_t          out_key_reg;

    akd_pkg::key_t          last_key_reg;
    akd_pkg::key_t          last_key_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic [TIME_BITS-1:0]   deadline_reg;
    logic [TIME_BITS-1:0]   deadline_next;
    akd_pkg::kind_t         kind_next;
    akd_pkg::key_t          ekey_next;

    logic                   advance;
    logic                   in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || events.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign in_take       = samples.valid && samples.ready;
    assign held_sample   = in_sample_reg;

    assign events.valid      = out_valid_reg;
    assign events.event_kind = out_kind_reg;
    assign events.event_key  = out_key_reg;

    always_comb
    begin
        last_key_next = last_key_reg;
        armed_next    = armed_reg;
        deadline_next = deadline_reg;
        kind_next     = akd_pkg::EV_NONE;
        ekey_next     = akd_pkg::KEY_NONE;
        if (key == last_key_reg)
        begin
            if (key != akd_pkg::KEY_NONE && armed_reg && in_time_reg >= deadline_reg)
            begin
                armed_next = 1'b0;
                kind_next  = akd_pkg::EV_LONG;
                ekey_next  = key;
            end
        end
        else if (last_key_reg == akd_pkg::KEY_NONE)
        begin
            deadline_next = in_time_reg + TIME_BITS'(regs.long_delay);
            armed_next    = 1'b1;
            kind_next     = akd_pkg::EV_DOWN;
            ekey_next     = key;
            last_key_next = key;
        end
        else if (key == akd_pkg::KEY_NONE)
        begin
            armed_next    = 1'b0;
            deadline_next = '0;
            kind_next     = akd_pkg::EV_UP;
            ekey_next     = last_key_reg;
            last_key_next = akd_pkg::KEY_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_key_reg  <= akd_pkg::KEY_NONE;
            armed_reg     <= 1'b0;
            deadline_reg  <= '0;
        end
        else
        begin
            if (samples.ready)
            begin
                in_valid_reg <= samples.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                last_key_reg  <= last_key_next;
                armed_reg     <= armed_next;
                deadline_reg  <= deadline_next;
            end
            else if (events.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg <= samples.adc_sample;
            in_time_reg   <= samples.now_time;
        end
        if (advance)
        begin
            out_kind_reg <= kind_next;
            out_key_reg  <= ekey_next;
        end
    end

endmodule

// File: rtl/analog_keypad_event_decoder.sv
`timescale 1ns / 1ps

// Decoder for a resistor-ladder keypad read through an ADC.
// Each transaction on the samples channel carries one ADC reading and a timestamp,
// and produces exactly one transaction on the events channel: an event kind
// (none, key down, key up, long press) and the key it concerns.
// The cfg channel writes the five ladder thresholds and the long-press delay; it
// is always ready and must be used only while no sample is in flight.
// An accepted sample is held in the input register and its event in the single
// event output register, from which it can be taken; one sample is accepted every
// cycle while the events receiver keeps taking events.
// When the events receiver stalls, the pending sample holds in the input register
// and samples.ready drops until the output register drains.
// Reset empties both pipeline registers, returns the thresholds and delay to their
// defaults, forgets the held key and disarms the long-press timer.
module analog_keypad_event_decoder #(
    parameter int SAMPLE_BITS = 10,
    parameter int TIME_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    akd_sample_if.sink  samples,
    akd_event_if.source events,
    akd_cfg_if.sink     cfg
);

    akd_pkg::cfg_t          regs;
    akd_pkg::key_t          key;
    logic [SAMPLE_BITS-1:0] held_sample;

    akd_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    akd_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .sample (held_sample),
        .regs   (regs),
        .key    (key)
    );

    akd_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .events      (events),
        .regs        (regs),
        .held_sample (held_sample),
        .key         (key)
    );

endmodule
